// ===== hw/rtl/wwtl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wwtl_pkg
// Shared types and constants of the word-wrap text layout unit: channel beats,
// configuration register indexes, character codes and control handshake types.
// ----------------------------------------------------------------------------
package wwtl_pkg;

    // sizes of the configuration port and the default word buffer depth
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int WORD_BUF_DEF = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 3'd4;

    // configuration reset values
    localparam logic [4:0] RST_START_COL    = 5'd0;
    localparam logic [4:0] RST_START_ROW    = 5'd0;
    localparam logic [4:0] RST_LINE_WIDTH   = 5'd12;
    localparam logic [4:0] RST_ROW_LIMIT    = 5'd5;
    localparam logic [7:0] RST_START_OFFSET = 8'd0;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NUL   = 8'd0;

    // input beat
    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } char_t;

    // output beat
    typedef struct packed {
        logic       is_status;
        logic [7:0] glyph;
        logic [5:0] col;
        logic [5:0] row;
        logic       finished;
        logic [7:0] next_offset;
        logic       last;
    } result_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GLYPH,
        ST_STATUS
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_glyph;
        logic load_status;
    } wwtl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic dec_glyphs;
        logic dec_status;
        logic glyph_last;
        logic stat_pend;
        logic out_free;
    } wwtl_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wwtl_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wwtl_ctrl
// Sequencer of the layout unit: takes one character, then streams the glyph
// beats of a released word and the end-of-page status beat.
// ----------------------------------------------------------------------------
module wwtl_ctrl
    import wwtl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      char_valid,
    output logic           char_stall,
    input  wire wwtl_sts_t sts,
    output wwtl_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        char_stall      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                char_stall = 1'b0;
                if (char_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.dec_glyphs)
                    begin
                        state_next = ST_GLYPH;
                    end
                    else if (sts.dec_status)
                    begin
                        state_next = ST_STATUS;
                    end
                end
            end
            ST_GLYPH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_glyph = 1'b1;
                    if (sts.glyph_last)
                    begin
                        state_next = sts.stat_pend ? ST_STATUS : ST_IDLE;
                    end
                end
            end
            ST_STATUS:
            begin
                if (sts.out_free)
                begin
                    cmd.load_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wwtl_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wwtl_datapath
// Layout state, configuration registers, word buffer and the output register.
// Decides a whole character in the accept cycle; glyphs are then read out of
// the word buffer one per beat.
// ----------------------------------------------------------------------------
module wwtl_datapath
    import wwtl_pkg::*;
#(
    parameter int WORD_BUF = WORD_BUF_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire char_t                 char_data,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result_data,
    input  wire wwtl_cmd_t             cmd,
    output wwtl_sts_t                  sts
);

    localparam int WL_W  = $clog2(WORD_BUF);
    localparam int CMP_W = ((WL_W > 6) ? WL_W : 6) + 1;
    localparam logic [CMP_W-1:0] BRK_MAX = CMP_W'(WORD_BUF - 1);

    // configuration
    logic [4:0] start_col_reg, start_row_reg, line_width_reg, row_limit_reg;
    logic [7:0] start_offset_reg;

    // layout state
    logic [5:0]      cur_row_reg, cur_row_next;
    logic [6:0]      cur_col_reg, cur_col_next;
    logic [5:0]      line_used_reg, line_used_next;
    logic [WL_W-1:0] word_len_reg, word_len_next;
    logic [7:0]      char_index_reg, char_index_next;
    logic [7:0]      word_begin_reg, word_begin_next;
    logic            page_done_reg, page_done_next;

    // word buffer
    logic [7:0] word_mem [WORD_BUF];
    logic       mem_we;

    // burst bookkeeping
    logic [WL_W-1:0] emit_idx_reg, emit_end_reg;
    logic [5:0]      base_col_reg, base_row_reg;
    logic            stat_pend_reg, fin_reg;
    logic [7:0]      nxt_reg;

    // output register
    logic    out_valid_reg;
    result_t out_reg;
    logic    out_free;

    // effective state once a page start is applied
    logic [5:0]       e_row, row_end, row_inc;
    logic [6:0]       e_col;
    logic [5:0]       e_used;
    logic [WL_W-1:0]  e_wlen, wlen_inc;
    logic [7:0]       e_cidx, e_wbeg, cidx_inc;
    logic             e_done;
    logic [CMP_W-1:0] brk;

    // decision of the accept cycle
    logic            d_glyphs, d_status, d_fin;
    logic [7:0]      d_nxt;
    logic [WL_W-1:0] d_count;
    logic [5:0]      d_base_col, d_base_row;
    logic            stop;

    assign out_free = !out_valid_reg || !result_stall;

    // page start and derived limits
    always_comb
    begin
        e_row    = char_data.first ? {1'b0, start_row_reg} : cur_row_reg;
        e_col    = char_data.first ? {2'b00, start_col_reg} : cur_col_reg;
        e_used   = char_data.first ? 6'd0 : line_used_reg;
        e_wlen   = char_data.first ? '0 : word_len_reg;
        e_cidx   = char_data.first ? start_offset_reg : char_index_reg;
        e_wbeg   = char_data.first ? start_offset_reg : word_begin_reg;
        e_done   = char_data.first ? 1'b0 : page_done_reg;
        row_end  = {1'b0, start_row_reg} + {1'b0, row_limit_reg};
        row_inc  = e_row + 6'd1;
        wlen_inc = e_wlen + WL_W'(1);
        cidx_inc = e_cidx + 8'd1;
        brk      = (CMP_W'(line_width_reg) > BRK_MAX) ? BRK_MAX : CMP_W'(line_width_reg);
    end

    // per-character layout decision
    always_comb
    begin
        cur_row_next    = e_row;
        cur_col_next    = e_col;
        line_used_next  = e_used;
        word_len_next   = e_wlen;
        char_index_next = e_cidx;
        word_begin_next = e_wbeg;
        page_done_next  = e_done;
        d_glyphs        = 1'b0;
        d_status        = 1'b0;
        d_fin           = 1'b0;
        d_nxt           = 8'd0;
        d_count         = e_wlen;
        d_base_col      = e_col[5:0];
        d_base_row      = e_row;
        mem_we          = 1'b0;
        stop            = 1'b0;
        if (e_done)
        begin
            // page over: item dropped
        end
        else if (e_row >= row_end)
        begin
            d_status = 1'b1;
            d_nxt    = e_wbeg;
        end
        else if (char_data.ch == CH_SPACE || char_data.ch == CH_NUL)
        begin
            if (e_wlen != '0)
            begin
                // wrap when the word does not fit on this line
                if ((CMP_W'(e_used) + CMP_W'(e_wlen)) > CMP_W'(line_width_reg))
                begin
                    cur_row_next   = row_inc;
                    cur_col_next   = {2'b00, start_col_reg};
                    line_used_next = 6'd0;
                    if (row_inc >= row_end)
                    begin
                        stop     = 1'b1;
                        d_status = 1'b1;
                        d_nxt    = e_wbeg;
                    end
                end
                if (!stop)
                begin
                    d_glyphs       = 1'b1;
                    d_base_col     = cur_col_next[5:0];
                    d_base_row     = cur_row_next;
                    cur_col_next   = cur_col_next + 7'(e_wlen)
                                     + ((char_data.ch == CH_SPACE) ? 7'd1 : 7'd0);
                    line_used_next = line_used_next + 6'(e_wlen)
                                     + ((char_data.ch == CH_SPACE) ? 6'd1 : 6'd0);
                    word_len_next  = '0;
                end
            end
            if (!stop)
            begin
                if (char_data.ch == CH_NUL)
                begin
                    d_status = 1'b1;
                    d_fin    = 1'b1;
                end
                else
                begin
                    char_index_next = cidx_inc;
                    word_begin_next = cidx_inc;
                end
            end
        end
        else
        begin
            // gather into the word, force-break at the break length
            mem_we = 1'b1;
            if (e_wlen == '0)
            begin
                word_begin_next = e_cidx;
            end
            word_len_next   = wlen_inc;
            char_index_next = cidx_inc;
            if (CMP_W'(wlen_inc) >= brk)
            begin
                d_glyphs        = 1'b1;
                d_count         = wlen_inc;
                word_len_next   = '0;
                cur_row_next    = row_inc;
                cur_col_next    = {2'b00, start_col_reg};
                line_used_next  = 6'd0;
                word_begin_next = cidx_inc;
            end
            if (cur_row_next >= row_end)
            begin
                d_status = 1'b1;
                d_nxt    = word_begin_next;
            end
        end
        if (d_status)
        begin
            page_done_next = 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_col_reg    <= RST_START_COL;
            start_row_reg    <= RST_START_ROW;
            line_width_reg   <= RST_LINE_WIDTH;
            row_limit_reg    <= RST_ROW_LIMIT;
            start_offset_reg <= RST_START_OFFSET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_COL:    start_col_reg    <= cfg_data[4:0];
                CFG_START_ROW:    start_row_reg    <= cfg_data[4:0];
                CFG_LINE_WIDTH:   line_width_reg   <= cfg_data[4:0];
                CFG_ROW_LIMIT:    row_limit_reg    <= cfg_data[4:0];
                CFG_START_OFFSET: start_offset_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // layout state and burst control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            line_used_reg  <= '0;
            word_len_reg   <= '0;
            char_index_reg <= '0;
            word_begin_reg <= '0;
            page_done_reg  <= 1'b0;
            emit_idx_reg   <= '0;
            emit_end_reg   <= '0;
            stat_pend_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                cur_row_reg    <= cur_row_next;
                cur_col_reg    <= cur_col_next;
                line_used_reg  <= line_used_next;
                word_len_reg   <= word_len_next;
                char_index_reg <= char_index_next;
                word_begin_reg <= word_begin_next;
                page_done_reg  <= page_done_next;
                emit_idx_reg   <= '0;
                emit_end_reg   <= d_count - WL_W'(1);
                stat_pend_reg  <= d_status;
            end
            else if (cmd.load_glyph)
            begin
                emit_idx_reg <= emit_idx_reg + WL_W'(1);
            end
            else if (cmd.load_status)
            begin
                stat_pend_reg <= 1'b0;
            end
            if (cmd.load_glyph || cmd.load_status)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // burst payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            base_col_reg <= d_base_col;
            base_row_reg <= d_base_row;
            fin_reg      <= d_fin;
            nxt_reg      <= d_nxt;
        end
    end

    // word buffer write
    always_ff @(posedge clk)
    begin
        if (cmd.accept && mem_we)
        begin
            word_mem[e_wlen] <= char_data.ch;
        end
    end

    // output register, glyph read straight from the word buffer
    always_ff @(posedge clk)
    begin
        if (cmd.load_glyph)
        begin
            out_reg.is_status   <= 1'b0;
            out_reg.glyph       <= word_mem[emit_idx_reg];
            out_reg.col         <= base_col_reg + 6'(emit_idx_reg);
            out_reg.row         <= base_row_reg;
            out_reg.finished    <= 1'b0;
            out_reg.next_offset <= 8'd0;
            out_reg.last        <= (emit_idx_reg == emit_end_reg) && !stat_pend_reg;
        end
        else if (cmd.load_status)
        begin
            out_reg.is_status   <= 1'b1;
            out_reg.glyph       <= 8'd0;
            out_reg.col         <= 6'd0;
            out_reg.row         <= 6'd0;
            out_reg.finished    <= fin_reg;
            out_reg.next_offset <= nxt_reg;
            out_reg.last        <= 1'b1;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // status to the controller
    assign sts.dec_glyphs = d_glyphs;
    assign sts.dec_status = d_status;
    assign sts.glyph_last = (emit_idx_reg == emit_end_reg);
    assign sts.stat_pend  = stat_pend_reg;
    assign sts.out_free   = out_free;

    // a burst never reads past its own word
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_glyph |-> emit_idx_reg <= emit_end_reg)
        else $error("glyph read beyond the released word");

    // the buffered word always leaves room for one more character
    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(word_len_reg) < BRK_MAX)
        else $error("word length reached the buffer limit");

    // a status beat is the last beat of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_status |=> result_valid && result_data.is_status && result_data.last)
        else $error("status beat not presented as last");

    // a status decision is remembered for the end of the burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && d_status) |=> stat_pend_reg && page_done_reg)
        else $error("status decision lost");

endmodule
`default_nettype wire

// ===== hw/rtl/word_wrap_text_layout_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// word_wrap_text_layout_unit
// Greedy word-wrap layout engine for a tile text window.
// ----------------------------------------------------------------------------
// Usage:
//   Character channel (char_valid / char_stall / char_data): one text byte per
//   beat; first marks the page's first byte. Result channel (result_valid /
//   result_stall / result_data): glyph beats with screen column and row, then
//   at the end of a page one status beat; last marks the final beat per byte.
//   Configuration registers are written through cfg_we / cfg_index / cfg_data
//   while the unit is idle.
//   Timing: a byte that releases a word keeps char_stall high while its glyph
//   beats and then any status beat are loaded into the output register. The
//   rate is set by the single read port of the word buffer, which gives one
//   glyph per cycle while the result side does not stall. A byte is taken in
//   the idle state; its first result beat is then loaded in the glyph or
//   status state, once the output register is free.
//   The output register lets the next byte be taken while the last beat of
//   the previous one still waits. A stall on the result side holds the beat
//   and pauses the glyph burst.
//   Reset puts configuration to its defaults and clears the layout state.
// ----------------------------------------------------------------------------
module word_wrap_text_layout_unit
    import wwtl_pkg::*;
#(
    parameter int WORD_BUF = WORD_BUF_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  char_valid,
    output logic                       char_stall,
    input  wire char_t                 char_data,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    wwtl_cmd_t cmd;
    wwtl_sts_t sts;

    // sequencer
    wwtl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // layout datapath
    wwtl_datapath #(
        .WORD_BUF (WORD_BUF)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
`default_nettype wire
